/* rtl/ffpa_pkg.sv */
package ffpa_pkg;

	localparam int unsigned AddrW  = 16;
	localparam int unsigned OwnerW = 8;
	localparam int unsigned SlackW = 8;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_NOJOB = 2'd3;

	localparam logic REG_TOTAL = 1'b0;
	localparam logic REG_SLACK = 1'b1;

	localparam logic [AddrW-1:0]  TOTAL_RST = 16'd1024;
	localparam logic [SlackW-1:0] SLACK_RST = 8'd2;

	localparam logic ACT_ALLOC   = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	typedef struct packed {
		logic [AddrW-1:0]  start;
		logic [AddrW-1:0]  len;
		logic [OwnerW-1:0] owner;
		logic              used;
	} entry_t;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_SC_RD, S_SC_EV, S_NX_RD, S_NX_EV, S_RL_WR,
		S_CP_CHK, S_CP_WR, S_AL_WA, S_AL_WB, S_RESP
	} state_t;

	typedef enum logic [1:0] {RS_IDX, RS_NEXT, RS_SRC} rd_sel_t;

	typedef enum logic [2:0] {
		WS_INIT, WS_GRANT, WS_COPY, WS_MERGE, WS_SPLIT_A, WS_SPLIT_B
	} wr_sel_t;

	typedef enum logic [2:0] {
		RES_HIT, RES_SPLIT, RES_NOFIT, RES_FULL, RES_NOJOB
	} res_sel_t;

	typedef struct packed {
		logic     init;
		logic     load;
		logic     idx_inc;
		logic     cap_cur;
		logic     cap_prev;
		logic     cap_next;
		logic     clr_next;
		logic     setup_down;
		logic     setup_up;
		logic     copy_step;
		logic     wr_en;
		wr_sel_t  wr_sel;
		rd_sel_t  rd_sel;
		logic     set_res;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		logic is_rel;
		logic scan_end;
		logic hit;
		logic whole;
		logic full;
		logic has_next;
		logic copy_done;
	} stat_t;

endpackage

/* rtl/ffpa_ram.sv */
module ffpa_ram #(
	parameter int unsigned WIDTH = 41,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/ffpa_ctrl.sv */
module ffpa_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           cfg_reinit,
	input  ffpa_pkg::stat_t stat,
	output ffpa_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done
);

	ffpa_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffpa_pkg::S_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		cmd.wr_sel = ffpa_pkg::WS_INIT;
		cmd.rd_sel = ffpa_pkg::RS_IDX;
		cmd.res_sel = ffpa_pkg::RES_HIT;
		unique case (state_q)
			ffpa_pkg::S_INIT: begin
				cmd.init = 1'b1;
				cmd.wr_en = 1'b1;
				cmd.wr_sel = ffpa_pkg::WS_INIT;
				state_nxt = cfg_reinit ? ffpa_pkg::S_INIT : ffpa_pkg::S_IDLE;
			end
			ffpa_pkg::S_IDLE: begin
				if (cfg_reinit) begin
					state_nxt = ffpa_pkg::S_INIT;
				end else if (start) begin
					cmd.load = 1'b1;
					state_nxt = ffpa_pkg::S_SC_RD;
				end
			end
			ffpa_pkg::S_SC_RD: begin
				if (stat.scan_end) begin
					cmd.set_res = 1'b1;
					cmd.res_sel = stat.is_rel ? ffpa_pkg::RES_NOJOB : ffpa_pkg::RES_NOFIT;
					state_nxt = ffpa_pkg::S_RESP;
				end else begin
					cmd.rd_sel = ffpa_pkg::RS_IDX;
					state_nxt = ffpa_pkg::S_SC_EV;
				end
			end
			ffpa_pkg::S_SC_EV: begin
				if (!stat.hit) begin
					cmd.cap_prev = 1'b1;
					cmd.idx_inc = 1'b1;
					state_nxt = ffpa_pkg::S_SC_RD;
				end else if (stat.is_rel) begin
					cmd.cap_cur = 1'b1;
					cmd.set_res = 1'b1;
					cmd.res_sel = ffpa_pkg::RES_HIT;
					state_nxt = ffpa_pkg::S_NX_RD;
				end else if (stat.whole) begin
					cmd.wr_en = 1'b1;
					cmd.wr_sel = ffpa_pkg::WS_GRANT;
					cmd.set_res = 1'b1;
					cmd.res_sel = ffpa_pkg::RES_HIT;
					state_nxt = ffpa_pkg::S_RESP;
				end else if (stat.full) begin
					cmd.set_res = 1'b1;
					cmd.res_sel = ffpa_pkg::RES_FULL;
					state_nxt = ffpa_pkg::S_RESP;
				end else begin
					cmd.cap_cur = 1'b1;
					cmd.setup_down = 1'b1;
					state_nxt = ffpa_pkg::S_CP_CHK;
				end
			end
			ffpa_pkg::S_NX_RD: begin
				if (stat.has_next) begin
					cmd.rd_sel = ffpa_pkg::RS_NEXT;
					state_nxt = ffpa_pkg::S_NX_EV;
				end else begin
					cmd.clr_next = 1'b1;
					state_nxt = ffpa_pkg::S_RL_WR;
				end
			end
			ffpa_pkg::S_NX_EV: begin
				cmd.cap_next = 1'b1;
				state_nxt = ffpa_pkg::S_RL_WR;
			end
			ffpa_pkg::S_RL_WR: begin
				cmd.wr_en = 1'b1;
				cmd.wr_sel = ffpa_pkg::WS_MERGE;
				cmd.setup_up = 1'b1;
				state_nxt = ffpa_pkg::S_CP_CHK;
			end
			ffpa_pkg::S_CP_CHK: begin
				if (stat.copy_done) begin
					state_nxt = stat.is_rel ? ffpa_pkg::S_RESP : ffpa_pkg::S_AL_WA;
				end else begin
					cmd.rd_sel = ffpa_pkg::RS_SRC;
					state_nxt = ffpa_pkg::S_CP_WR;
				end
			end
			ffpa_pkg::S_CP_WR: begin
				cmd.wr_en = 1'b1;
				cmd.wr_sel = ffpa_pkg::WS_COPY;
				cmd.copy_step = 1'b1;
				state_nxt = ffpa_pkg::S_CP_CHK;
			end
			ffpa_pkg::S_AL_WA: begin
				cmd.wr_en = 1'b1;
				cmd.wr_sel = ffpa_pkg::WS_SPLIT_A;
				state_nxt = ffpa_pkg::S_AL_WB;
			end
			ffpa_pkg::S_AL_WB: begin
				cmd.wr_en = 1'b1;
				cmd.wr_sel = ffpa_pkg::WS_SPLIT_B;
				cmd.set_res = 1'b1;
				cmd.res_sel = ffpa_pkg::RES_SPLIT;
				state_nxt = ffpa_pkg::S_RESP;
			end
			ffpa_pkg::S_RESP: begin
				state_nxt = ffpa_pkg::S_IDLE;
			end
			default: begin
				state_nxt = ffpa_pkg::S_INIT;
			end
		endcase
	end

	assign busy = (state_q != ffpa_pkg::S_IDLE);
	assign done = (state_q == ffpa_pkg::S_RESP);

	a_resp_after_hit_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ffpa_pkg::S_AL_WB) |=> done)
		else $error("split did not complete with a response");

endmodule

/* rtl/ffpa_dp.sv */
module ffpa_dp #(
	parameter int unsigned MAX_PARTS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ffpa_pkg::cmd_t                cmd,
	output ffpa_pkg::stat_t               stat,
	input  logic                          action,
	input  logic [ffpa_pkg::OwnerW-1:0]   job_id,
	input  logic [ffpa_pkg::AddrW-1:0]    request_size,
	input  logic [ffpa_pkg::AddrW-1:0]    total_size,
	input  logic [ffpa_pkg::SlackW-1:0]   split_slack,
	output logic [1:0]                    status,
	output logic [ffpa_pkg::AddrW-1:0]    grant_base,
	output logic [ffpa_pkg::AddrW-1:0]    granted_size
);

	localparam int unsigned CW = $clog2(MAX_PARTS + 1);
	localparam int unsigned AW = $clog2(MAX_PARTS);
	localparam int unsigned EW = $bits(ffpa_pkg::entry_t);

	logic [CW-1:0] cnt_q, idx_q, dst_q, src_q;
	logic act_q;
	logic [ffpa_pkg::OwnerW-1:0] job_q;
	logic [ffpa_pkg::AddrW-1:0] req_q;
	ffpa_pkg::entry_t cur_q, prev_q, rd_ent, wr_ent, merge_ent;
	logic nxt_free_q;
	logic [ffpa_pkg::AddrW-1:0] nxt_len_q, merge_len, leftover;
	logic [1:0] res_status_q;
	logic [ffpa_pkg::AddrW-1:0] res_start_q, res_size_q;
	logic [CW-1:0] wr_idx, rd_idx, merge_tgt, rm_first, rm_cnt, idx_p1;
	logic [EW-1:0] rd_word;
	logic prev_free;

	assign rd_ent = ffpa_pkg::entry_t'(rd_word);
	assign idx_p1 = idx_q + CW'(1);
	assign leftover = rd_ent.len - req_q;

	assign prev_free = (idx_q != '0) && !prev_q.used;
	assign merge_len = (prev_free ? prev_q.len : '0) + cur_q.len
		+ (nxt_free_q ? nxt_len_q : '0);
	assign merge_tgt = prev_free ? idx_q - CW'(1) : idx_q;
	assign rm_first = prev_free ? idx_q : idx_p1;
	assign rm_cnt = CW'(prev_free) + CW'(nxt_free_q);

	always_comb begin
		merge_ent = cur_q;
		merge_ent.len = merge_len;
		merge_ent.owner = '0;
		merge_ent.used = 1'b0;
		if (prev_free) begin
			merge_ent.start = prev_q.start;
			merge_ent.owner = prev_q.owner;
		end
	end

	always_comb begin
		unique case (cmd.rd_sel)
			ffpa_pkg::RS_IDX:  rd_idx = idx_q;
			ffpa_pkg::RS_NEXT: rd_idx = idx_p1;
			ffpa_pkg::RS_SRC:  rd_idx = src_q;
			default:           rd_idx = idx_q;
		endcase
	end

	always_comb begin
		wr_idx = idx_q;
		wr_ent = rd_ent;
		unique case (cmd.wr_sel)
			ffpa_pkg::WS_INIT: begin
				wr_idx = '0;
				wr_ent = '0;
				wr_ent.len = total_size;
			end
			ffpa_pkg::WS_GRANT: begin
				wr_ent.owner = job_q;
				wr_ent.used = 1'b1;
			end
			ffpa_pkg::WS_COPY: begin
				wr_idx = dst_q;
			end
			ffpa_pkg::WS_MERGE: begin
				wr_idx = merge_tgt;
				wr_ent = merge_ent;
			end
			ffpa_pkg::WS_SPLIT_A: begin
				wr_ent.start = cur_q.start;
				wr_ent.len = req_q;
				wr_ent.owner = job_q;
				wr_ent.used = 1'b1;
			end
			ffpa_pkg::WS_SPLIT_B: begin
				wr_idx = idx_p1;
				wr_ent.start = cur_q.start + req_q;
				wr_ent.len = cur_q.len - req_q;
				wr_ent.owner = cur_q.owner;
				wr_ent.used = 1'b0;
			end
			default: begin
				wr_idx = idx_q;
			end
		endcase
	end

	ffpa_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_PARTS)
	) u_table (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(wr_idx[AW-1:0]),
		.wdata(EW'(wr_ent)),
		.raddr(rd_idx[AW-1:0]),
		.rdata(rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CW'(1);
			idx_q <= '0;
			dst_q <= '0;
			src_q <= '0;
			act_q <= ffpa_pkg::ACT_ALLOC;
		end else begin
			if (cmd.init) begin
				cnt_q <= CW'(1);
			end
			if (cmd.load) begin
				act_q <= action;
				idx_q <= '0;
			end
			if (cmd.idx_inc) begin
				idx_q <= idx_p1;
			end
			if (cmd.setup_down) begin
				dst_q <= cnt_q;
				src_q <= cnt_q - CW'(1);
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.setup_up) begin
				dst_q <= rm_first;
				src_q <= rm_first + rm_cnt;
				cnt_q <= cnt_q - rm_cnt;
			end
			if (cmd.copy_step) begin
				if (act_q == ffpa_pkg::ACT_RELEASE) begin
					dst_q <= dst_q + CW'(1);
					src_q <= src_q + CW'(1);
				end else begin
					dst_q <= dst_q - CW'(1);
					src_q <= src_q - CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			job_q <= job_id;
			req_q <= request_size;
		end
		if (cmd.cap_cur) begin
			cur_q <= rd_ent;
		end
		if (cmd.cap_prev) begin
			prev_q <= rd_ent;
		end
		if (cmd.cap_next) begin
			nxt_free_q <= !rd_ent.used;
			nxt_len_q <= rd_ent.len;
		end
		if (cmd.clr_next) begin
			nxt_free_q <= 1'b0;
			nxt_len_q <= '0;
		end
		if (cmd.set_res) begin
			case (cmd.res_sel)
				ffpa_pkg::RES_HIT: begin
					res_status_q <= ffpa_pkg::ST_OK;
					res_start_q <= rd_ent.start;
					res_size_q <= rd_ent.len;
				end
				ffpa_pkg::RES_SPLIT: begin
					res_status_q <= ffpa_pkg::ST_OK;
					res_start_q <= cur_q.start;
					res_size_q <= req_q;
				end
				ffpa_pkg::RES_NOFIT: begin
					res_status_q <= ffpa_pkg::ST_NOFIT;
					res_start_q <= '0;
					res_size_q <= '0;
				end
				ffpa_pkg::RES_FULL: begin
					res_status_q <= ffpa_pkg::ST_FULL;
					res_start_q <= '0;
					res_size_q <= '0;
				end
				default: begin
					res_status_q <= ffpa_pkg::ST_NOJOB;
					res_start_q <= '0;
					res_size_q <= '0;
				end
			endcase
		end
	end

	always_comb begin
		stat.is_rel = (act_q == ffpa_pkg::ACT_RELEASE);
		stat.scan_end = (idx_q == cnt_q);
		if (stat.is_rel) begin
			stat.hit = rd_ent.used && (rd_ent.owner == job_q);
		end else begin
			stat.hit = !rd_ent.used && (req_q != '0) && (rd_ent.len >= req_q);
		end
		stat.whole = (leftover <= {{(ffpa_pkg::AddrW - ffpa_pkg::SlackW){1'b0}}, split_slack});
		stat.full = (cnt_q >= CW'(MAX_PARTS));
		stat.has_next = (idx_p1 < cnt_q);
		if (stat.is_rel) begin
			stat.copy_done = (dst_q >= cnt_q) || (src_q == dst_q);
		end else begin
			stat.copy_done = (dst_q == idx_q);
		end
	end

	assign status = res_status_q;
	assign grant_base = res_start_q;
	assign granted_size = res_size_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) && (cnt_q <= CW'(MAX_PARTS)))
		else $error("partition count out of range");

endmodule

/* rtl/first_fit_partition_allocator_unit.sv */
// First-fit partition allocator. Pulse start while busy is low to issue an allocate
// (action 0) or release (action 1) transaction; exactly one result follows,
// flagged by done for a single cycle, which must be captured then since the
// receiver cannot stall it. The table lives in a one-read one-write RAM, so
// the controller reads each entry scanned and evaluates it in a separate
// state, and moves each entry shifted on a split or merge with a read state
// followed by a write state. After reset, and after a write of total_size
// while the unit is idle, busy stays high while entry 0 is rewritten as a
// single free partition.
module first_fit_partition_allocator_unit #(
	parameter int unsigned MAX_PARTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic        action,
	input  logic [7:0]  job_id,
	input  logic [15:0] request_size,
	output logic [1:0]  status,
	output logic [15:0] grant_base,
	output logic [15:0] granted_size,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [ffpa_pkg::AddrW-1:0] total_q;
	logic [ffpa_pkg::SlackW-1:0] slack_q;
	logic cfg_wr, cfg_reinit;
	ffpa_pkg::cmd_t cmd;
	ffpa_pkg::stat_t stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign cfg_reinit = cfg_wr && (paddr[2] == ffpa_pkg::REG_TOTAL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= ffpa_pkg::TOTAL_RST;
			slack_q <= ffpa_pkg::SLACK_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				ffpa_pkg::REG_TOTAL: total_q <= pwdata[15:0];
				ffpa_pkg::REG_SLACK: slack_q <= pwdata[7:0];
				default: total_q <= total_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			ffpa_pkg::REG_TOTAL: prdata = {16'd0, total_q};
			ffpa_pkg::REG_SLACK: prdata = {24'd0, slack_q};
			default: prdata = '0;
		endcase
	end

	ffpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cfg_reinit(cfg_reinit),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	ffpa_dp #(
		.MAX_PARTS(MAX_PARTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.action       (action),
		.job_id       (job_id),
		.request_size (request_size),
		.total_size   (total_q),
		.split_slack  (slack_q),
		.status       (status),
		.grant_base   (grant_base),
		.granted_size (granted_size)
	);

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !cfg_wr) |=> busy)
		else $error("accepted transaction did not raise busy");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ffpa_pkg::ST_OK)) |-> (grant_base == '0) && (granted_size == '0))
		else $error("failed transaction carries nonzero fields");

endmodule
